FILE: sv/ntctm_pkg.sv
// ----------------------------------------------------------------------------
// ntctm_pkg
// Shared constants, threshold table and controller/datapath signal groups
// for the NTC trimmed-mean temperature block.
// ----------------------------------------------------------------------------
package ntctm_pkg;

  // field widths
  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 16;
  localparam int COUNT_W  = 4;
  localparam int MEAN_W   = 13;
  localparam int ROM_W    = 13;
  localparam int TEMP_W   = 7;

  // threshold table geometry
  localparam int TABLE_DEPTH_DEF = 125;
  localparam int IDX_W           = $clog2(TABLE_DEPTH_DEF);

  // group and result constants
  localparam logic [COUNT_W-1:0] LAST_IN_GROUP = COUNT_W'(9);
  localparam logic [IDX_W-1:0]   SHORT_LIMIT   = IDX_W'(2);
  localparam logic [IDX_W-1:0]   OPEN_INDEX    = IDX_W'(124);
  localparam logic [IDX_W-1:0]   INDEX_OFFSET  = IDX_W'(22);
  localparam logic [TEMP_W-1:0]  TEMP_MAX      = TEMP_W'(99);

  // ascending divider thresholds, one per table index
  localparam logic [ROM_W-1:0] THRESHOLD_ROM [0:TABLE_DEPTH_DEF-1] = '{
    13'd0,    13'd200,  13'd405,  13'd425,  13'd445,  13'd466,  13'd488,  13'd511,
    13'd534,  13'd559,  13'd584,  13'd610,  13'd637,  13'd665,  13'd694,  13'd723,
    13'd754,  13'd786,  13'd819,  13'd853,  13'd887,  13'd923,  13'd960,  13'd998,
    13'd1037, 13'd1077, 13'd1117, 13'd1158, 13'd1200, 13'd1242, 13'd1284, 13'd1327,
    13'd1371, 13'd1415, 13'd1459, 13'd1504, 13'd1549, 13'd1594, 13'd1639, 13'd1684,
    13'd1730, 13'd1776, 13'd1821, 13'd1867, 13'd1912, 13'd1958, 13'd2003, 13'd2048,
    13'd2094, 13'd2139, 13'd2184, 13'd2228, 13'd2272, 13'd2316, 13'd2358, 13'd2401,
    13'd2442, 13'd2483, 13'd2523, 13'd2563, 13'd2602, 13'd2640, 13'd2678, 13'd2715,
    13'd2751, 13'd2787, 13'd2821, 13'd2855, 13'd2889, 13'd2921, 13'd2953, 13'd2984,
    13'd3014, 13'd3044, 13'd3073, 13'd3101, 13'd3129, 13'd3156, 13'd3182, 13'd3207,
    13'd3232, 13'd3257, 13'd3280, 13'd3303, 13'd3325, 13'd3347, 13'd3368, 13'd3389,
    13'd3409, 13'd3428, 13'd3447, 13'd3466, 13'd3484, 13'd3501, 13'd3518, 13'd3534,
    13'd3550, 13'd3566, 13'd3581, 13'd3595, 13'd3610, 13'd3623, 13'd3637, 13'd3650,
    13'd3662, 13'd3674, 13'd3686, 13'd3698, 13'd3709, 13'd3720, 13'd3730, 13'd3741,
    13'd3751, 13'd3760, 13'd3770, 13'd3779, 13'd3788, 13'd3796, 13'd3804, 13'd3812,
    13'd3820, 13'd3828, 13'd3835, 13'd3900, 13'd4096
  };

  // controller to datapath
  typedef struct packed {
    logic take;   // sample item accepted this cycle
    logic step;   // advance table index
    logic load;   // capture result into output register
  } ntctm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_sample;  // current sample closes the group
    logic found;        // search has stopped at the current index
  } ntctm_status_t;

endpackage

FILE: sv/ntctm_if.sv
// ----------------------------------------------------------------------------
// ntctm_if
// Valid/ready channels for sample items and temperature result items.
// ----------------------------------------------------------------------------
interface ntctm_in_if
  import ntctm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface ntctm_out_if
  import ntctm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [TEMP_W-1:0] temperature;
  logic              sensor_fault;

  modport source (output valid, output temperature, output sensor_fault, input ready);
  modport sink   (input valid, input temperature, input sensor_fault, output ready);
endinterface

FILE: sv/ntctm_ctrl.sv
// ----------------------------------------------------------------------------
// ntctm_ctrl
// Controller: sample intake, table search sequencing and output handshake.
// ----------------------------------------------------------------------------
module ntctm_ctrl
  import ntctm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ntctm_status_t status,
  output ntctm_cmd_t    cmd
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic out_free;

  // handshake and commands
  always_comb begin
    in_ready = (state == ST_IDLE);
    out_free = !out_valid || out_ready;
    cmd.take = in_valid && (state == ST_IDLE);
    cmd.step = (state == ST_SEARCH) && !status.found;
    cmd.load = (state == ST_SEARCH) && status.found && out_free;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.take && status.last_sample) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (cmd.load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // output slot occupancy
  always_comb begin
    priority if (cmd.load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: sv/ntctm_datapath.sv
// ----------------------------------------------------------------------------
// ntctm_datapath
// Group accumulator with max/min tracking, trimmed mean, sequential
// threshold walk and result mapping.
// ----------------------------------------------------------------------------
module ntctm_datapath
  import ntctm_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ntctm_cmd_t          cmd,
  input  logic [SAMPLE_W-1:0] sample,
  output ntctm_status_t       status,
  output logic [TEMP_W-1:0]   temperature,
  output logic                sensor_fault
);

  localparam int DP_IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [DP_IDX_W-1:0] LAST_IDX = DP_IDX_W'(TABLE_DEPTH - 1);

  logic [SUM_W-1:0]    sum;
  logic [COUNT_W-1:0]  sample_count;
  logic [SAMPLE_W-1:0] largest;
  logic [SAMPLE_W-1:0] smallest;
  logic [MEAN_W-1:0]   mean;
  logic [DP_IDX_W-1:0] idx;

  logic [SUM_W-1:0]    sum_next;
  logic [SAMPLE_W-1:0] largest_next;
  logic [SAMPLE_W-1:0] smallest_next;
  logic [SUM_W-1:0]    trimmed;
  logic [ROM_W-1:0]    threshold;
  logic                fault_next;
  logic [TEMP_W-1:0]   temp_next;
  logic [TEMP_W-1:0]   offset_idx;

  // running sum and extremes with the new sample
  always_comb begin
    sum_next = sum + SUM_W'(sample);
    if (sample_count == '0) begin
      largest_next  = sample;
      smallest_next = sample;
    end else if (sample > largest) begin
      largest_next  = sample;
      smallest_next = smallest;
    end else if (sample < smallest) begin
      largest_next  = largest;
      smallest_next = sample;
    end else begin
      largest_next  = largest;
      smallest_next = smallest;
    end
    trimmed = sum_next - SUM_W'(largest_next) - SUM_W'(smallest_next);
    status.last_sample = (sample_count == LAST_IN_GROUP);

    // table walk stop condition
    threshold    = THRESHOLD_ROM[IDX_W'(idx)];
    status.found = (idx == LAST_IDX) || (mean <= threshold);
  end

  // index to temperature, faults at both table ends
  always_comb begin
    fault_next = (idx <= DP_IDX_W'(SHORT_LIMIT)) || (idx == DP_IDX_W'(OPEN_INDEX));
    offset_idx = TEMP_W'(idx) - TEMP_W'(INDEX_OFFSET);
    if (fault_next || (TEMP_W'(idx) < TEMP_W'(INDEX_OFFSET))) begin
      temp_next = '0;
    end else if (offset_idx > TEMP_MAX) begin
      temp_next = TEMP_MAX;
    end else begin
      temp_next = offset_idx;
    end
  end

  // group accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      sum          <= '0;
      sample_count <= '0;
      largest      <= '0;
      smallest     <= '0;
    end else if (cmd.take) begin
      largest  <= largest_next;
      smallest <= smallest_next;
      if (status.last_sample) begin
        sum          <= '0;
        sample_count <= '0;
      end else begin
        sum          <= sum_next;
        sample_count <= sample_count + COUNT_W'(1);
      end
    end
  end

  // mean capture and search index
  always_ff @(posedge clk) begin
    if (cmd.take && status.last_sample) begin
      mean <= trimmed[SUM_W-1:3];
      idx  <= '0;
    end else if (cmd.step) begin
      idx <= idx + DP_IDX_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      temperature  <= temp_next;
      sensor_fault <= fault_next;
    end
  end

endmodule

FILE: sv/ntc_trimmed_mean_temperature.sv
// A sample that does not close its group of ten gives no result and the block
// is ready again on the next cycle. The tenth sample starts a walk over the
// threshold table, one entry per cycle, and its result is registered where
// the walk stops; samples wait meanwhile. A full result still held at the
// output delays the hand-over of the next one, and samples wait until that
// hand-over. Reset clears the accumulator, controller state and valid flag.
// ----------------------------------------------------------------------------
// ntc_trimmed_mean_temperature
// Trimmed-mean filter of NTC divider samples with table lookup to degrees C.
// ----------------------------------------------------------------------------
module ntc_trimmed_mean_temperature
  import ntctm_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input logic         clk,
  input logic         rst,
  ntctm_in_if.sink    samples,
  ntctm_out_if.source results
);

  ntctm_cmd_t    cmd;
  ntctm_status_t status;

  // sequencing
  ntctm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic and table walk
  ntctm_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sample       (samples.sample),
    .status       (status),
    .temperature  (results.temperature),
    .sensor_fault (results.sensor_fault)
  );

endmodule

FILE: sv/ntctm_checker.sv
// ----------------------------------------------------------------------------
// ntctm_checker
// Port-level checks: result range, fault encoding, no result without a
// completed group and held result while stalled.
// ----------------------------------------------------------------------------
module ntctm_checker
  import ntctm_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [TEMP_W-1:0]   temperature,
  input logic                sensor_fault
);

  logic [COUNT_W-1:0] seen;
  logic [1:0]         pending;
  logic               in_acc;
  logic               out_acc;
  logic               group_end;

  always_comb begin
    in_acc    = in_valid && in_ready;
    out_acc   = out_valid && out_ready;
    group_end = in_acc && (seen == LAST_IN_GROUP);
  end

  // samples in group and groups not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      seen    <= '0;
      pending <= '0;
    end else begin
      if (in_acc) seen <= (seen == LAST_IN_GROUP) ? '0 : seen + COUNT_W'(1);
      pending <= pending + 2'(group_end) - 2'(out_acc);
    end
  end

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> temperature <= TEMP_MAX)
    else $error("temperature above clamp");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && sensor_fault |-> temperature == '0)
    else $error("fault result with nonzero temperature");

  a_group_owed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result item without a completed group");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(temperature) && $stable(sensor_fault))
    else $error("stalled result item changed");

endmodule

bind ntc_trimmed_mean_temperature ntctm_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (samples.valid),
  .in_ready     (samples.ready),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .temperature  (results.temperature),
  .sensor_fault (results.sensor_fault)
);
